// File: rtl/xsrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsrr_pkg
// Shared types and constants of the xorshift64 range random unit.
// ----------------------------------------------------------------------------
package xsrr_pkg;

    localparam int          WORD_W      = 64;
    localparam int          LEN_W       = 32;
    localparam int          FRAC_W      = 53;
    localparam int          OP_W        = 2;
    localparam int          IN_TDATA_W  = 224;  // seed, low, high, length
    localparam int          OUT_FIELD_W = 117;  // fraction, draw value
    localparam int          OUT_TDATA_W = 120;  // padded to whole bytes
    localparam int          DIV_STEPS   = 64;
    localparam logic [63:0] SEED_MIX    = 64'h9E37_79B9_7F4A_7C15;

    // Operation code carried on the input tuser
    typedef enum logic [OP_W-1:0] {
        OP_SEED  = 2'd0,
        OP_FRAC  = 2'd1,
        OP_RANGE = 2'd2,
        OP_INDEX = 2'd3
    } t_op;

    // Work kind decided by the front end
    typedef enum logic [2:0] {
        K_SEED,
        K_FRAC,
        K_MOD,
        K_WRAP,
        K_ERR
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [WORD_W-1:0] arg;      // seed, or offset added to the result
        logic [WORD_W-1:0] divisor;  // modulus for K_MOD, never zero
    } t_cmd;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DIV,
        BS_FIN
    } t_bstate;

endpackage

// File: rtl/xsrr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsrr_front
// Accepts items, classifies them into work commands and queues them.
// ----------------------------------------------------------------------------
module xsrr_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [xsrr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [xsrr_pkg::OP_W-1:0]        s_axis_tuser,
    input  logic                             i_pop,
    output logic                             o_cmd_valid,
    output xsrr_pkg::t_cmd                   o_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    xsrr_pkg::t_cmd r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;

    logic [63:0]    w_seed, w_low, w_high, w_span;
    logic [31:0]    w_len;
    xsrr_pkg::t_op  w_op;
    xsrr_pkg::t_cmd w_cmd;
    logic           w_push, w_pop;

    assign w_seed = s_axis_tdata[63:0];
    assign w_low  = s_axis_tdata[127:64];
    assign w_high = s_axis_tdata[191:128];
    assign w_len  = s_axis_tdata[223:192];
    assign w_op   = xsrr_pkg::t_op'(s_axis_tuser);
    assign w_span = w_high - w_low + 64'd1;

    // classify
    always_comb begin
        w_cmd.kind    = xsrr_pkg::K_ERR;
        w_cmd.arg     = '0;
        w_cmd.divisor = 64'd1;
        unique case (w_op)
            xsrr_pkg::OP_SEED: begin
                w_cmd.kind = xsrr_pkg::K_SEED;
                w_cmd.arg  = w_seed;
            end
            xsrr_pkg::OP_FRAC: begin
                w_cmd.kind = xsrr_pkg::K_FRAC;
            end
            xsrr_pkg::OP_RANGE: begin
                if ($signed(w_low) > $signed(w_high)) begin
                    w_cmd.kind = xsrr_pkg::K_ERR;
                end else if (w_span == 64'd0) begin
                    w_cmd.kind = xsrr_pkg::K_WRAP;
                    w_cmd.arg  = w_low;
                end else begin
                    w_cmd.kind    = xsrr_pkg::K_MOD;
                    w_cmd.arg     = w_low;
                    w_cmd.divisor = w_span;
                end
            end
            xsrr_pkg::OP_INDEX: begin
                if (w_len != 32'd0) begin
                    w_cmd.kind    = xsrr_pkg::K_MOD;
                    w_cmd.divisor = {32'd0, w_len};
                end
            end
            default: w_cmd.kind = xsrr_pkg::K_ERR;
        endcase
    end

    assign s_axis_tready = (r_cnt != CNT_FULL);
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_cmd_valid   = (r_cnt != '0);
    assign w_pop         = i_pop && o_cmd_valid;
    assign o_cmd         = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_FULL)
        else $error("queue count beyond depth");

endmodule

// File: rtl/xsrr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsrr_back
// Holds the xorshift word, executes queued commands, radix-2 remainder unit
// and the result register.
// ----------------------------------------------------------------------------
module xsrr_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    input  xsrr_pkg::t_cmd                    i_cmd,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [xsrr_pkg::FRAC_W-1:0]       o_fraction,
    output logic [xsrr_pkg::WORD_W-1:0]       o_draw_value,
    output logic                              o_error
);

    localparam int STEP_W = $clog2(xsrr_pkg::DIV_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(xsrr_pkg::DIV_STEPS - 1);

    function automatic logic [63:0] xs_advance(input logic [63:0] w);
        logic [63:0] t;
        t = w ^ (w << 13);
        t = t ^ (t >> 7);
        t = t ^ (t << 17);
        return t;
    endfunction

    xsrr_pkg::t_bstate r_state, n_state;
    logic [63:0] r_word, n_word;
    logic [63:0] r_rem, n_rem;   // partial remainder
    logic [63:0] r_dvd, n_dvd;   // dividend bits still to shift in
    logic [63:0] r_div, n_div;
    logic [63:0] r_off, n_off;
    logic [STEP_W-1:0] r_step, n_step;
    logic        r_out_valid, n_out_valid;
    logic [52:0] r_frac, n_frac;
    logic [63:0] r_draw, n_draw;
    logic        r_err, n_err;

    logic [63:0] w_adv, w_seeded;
    logic [64:0] w_trial;
    logic        w_out_free;

    assign w_adv      = xs_advance(r_word);
    assign w_seeded   = i_cmd.arg ^ xsrr_pkg::SEED_MIX;
    assign w_trial    = {r_rem, r_dvd[63]};
    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state     = r_state;
        n_word      = r_word;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_div       = r_div;
        n_off       = r_off;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_ready;
        n_frac      = r_frac;
        n_draw      = r_draw;
        n_err       = r_err;
        o_pop       = 1'b0;
        unique case (r_state)
            xsrr_pkg::BS_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    o_pop  = 1'b1;
                    n_frac = '0;
                    n_draw = '0;
                    n_err  = 1'b0;
                    unique case (i_cmd.kind)
                        xsrr_pkg::K_SEED: begin
                            n_word      = (w_seeded == 64'd0) ? 64'd1 : w_seeded;
                            n_out_valid = 1'b1;
                        end
                        xsrr_pkg::K_FRAC: begin
                            n_word      = w_adv;
                            n_frac      = w_adv[63:11];
                            n_out_valid = 1'b1;
                        end
                        xsrr_pkg::K_WRAP: begin
                            n_word      = w_adv;
                            n_draw      = i_cmd.arg + w_adv;
                            n_out_valid = 1'b1;
                        end
                        xsrr_pkg::K_MOD: begin
                            n_word  = w_adv;
                            n_dvd   = w_adv;
                            n_rem   = '0;
                            n_div   = i_cmd.divisor;
                            n_off   = i_cmd.arg;
                            n_step  = '0;
                            n_state = xsrr_pkg::BS_DIV;
                        end
                        default: begin
                            n_err       = 1'b1;
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            xsrr_pkg::BS_DIV: begin
                // one restoring step per cycle, quotient discarded
                if (w_trial >= {1'b0, r_div}) begin
                    n_rem = 64'(w_trial - {1'b0, r_div});
                end else begin
                    n_rem = w_trial[63:0];
                end
                n_dvd  = r_dvd << 1;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_LAST) begin
                    n_state = xsrr_pkg::BS_FIN;
                end
            end
            xsrr_pkg::BS_FIN: begin
                if (w_out_free) begin
                    n_draw      = r_off + r_rem;
                    n_frac      = '0;
                    n_err       = 1'b0;
                    n_out_valid = 1'b1;
                    n_state     = xsrr_pkg::BS_IDLE;
                end
            end
            default: n_state = xsrr_pkg::BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xsrr_pkg::BS_IDLE;
            r_word      <= xsrr_pkg::SEED_MIX;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_word      <= n_word;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
        r_div  <= n_div;
        r_off  <= n_off;
        r_frac <= n_frac;
        r_draw <= n_draw;
        r_err  <= n_err;
    end

    assign o_valid      = r_out_valid;
    assign o_fraction   = r_frac;
    assign o_draw_value = r_draw;
    assign o_error      = r_err;

    a_word_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word != 64'd0)
        else $error("xorshift word reached zero");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == xsrr_pkg::BS_DIV |-> r_div != 64'd0)
        else $error("remainder unit started with zero divisor");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == xsrr_pkg::BS_FIN |-> r_rem < r_div)
        else $error("remainder not below divisor");

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |=> r_out_valid && $stable(r_draw))
        else $error("pending result dropped or changed");

endmodule

// File: rtl/xorshift64_range_random_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xorshift64_range_random_unit
// 64-bit xorshift (13, 7, 17) generator giving fraction, range and index
// draws; a classifying front end feeds a command queue and an execution back
// end with a radix-2 remainder unit.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | tdata (low bit up)                        | tuser
// ---------+-----+-------------------------------------------+-------------
// s_axis   | in  | seed_value, low_bound, high_bound,        | operation
//          |     | list_length (224 bits)                    |
// m_axis   | out | fraction, draw_value, 3 pad bits (120)    | error
//
// Seed, fraction draw, full-span range draw and any error item: the result is
// registered at dispatch. Range and index draws that need a remainder pass
// through dispatch, 64 one-bit divide steps and a final add in the remainder unit.
// Reset (synchronous, active low) loads the word with the mixing constant and
// empties the queue and result register.
// The queue of QUEUE_DEPTH commands keeps s_axis taking items while the back
// end divides or m_axis stalls; a finished item waits in the result register.
// ----------------------------------------------------------------------------
module xorshift64_range_random_unit #(
    parameter int QUEUE_DEPTH = 2   // command queue entries, 1 to 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input items
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [63:0] seed_value, [127:64] low_bound, [191:128] high_bound,
    // [223:192] list_length
    input  logic [xsrr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] operation
    input  logic [xsrr_pkg::OP_W-1:0]          s_axis_tuser,
    // result items
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [52:0] fraction, [116:53] draw_value, [119:117] zero
    output logic [xsrr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [0] error
    output logic                               m_axis_tuser
);

    xsrr_pkg::t_cmd w_cmd;
    logic           w_cmd_valid;
    logic           w_pop;
    logic [xsrr_pkg::FRAC_W-1:0] w_fraction;
    logic [xsrr_pkg::WORD_W-1:0] w_draw_value;

    // front: decode operation, check bounds, work out the span, queue it
    xsrr_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_pop         (w_pop),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd)
    );

    // back: word update, remainder, result register
    xsrr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_cmd),
        .o_pop        (w_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_fraction   (w_fraction),
        .o_draw_value (w_draw_value),
        .o_error      (m_axis_tuser)
    );

    assign m_axis_tdata = {(xsrr_pkg::OUT_TDATA_W - xsrr_pkg::OUT_FIELD_W)'(0),
                           w_draw_value, w_fraction};

endmodule
